// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the redness mask block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RMDB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmdb assertion failed");

// next-cycle implication
`define RMDB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmdb assertion failed");

`endif

// File: src/rmdb_pkg.sv
// ----------------------------------------------------------------------------
// rmdb_pkg
// Constants and types for the redness mask dilate and border block.
// ----------------------------------------------------------------------------
package rmdb_pkg;

   localparam int DEF_MAX_WIDTH = 2048;
   localparam int CFG_W         = 12;
   localparam int ROW_W         = 13;
   localparam int PIX_W         = 8;
   localparam int REQ_DATA_W    = 3 * PIX_W;
   localparam int RSP_DATA_W    = 8;
   localparam int REG_IDX_W     = 1;
   localparam int NUM_STAGES    = 3;
   localparam int PAIR_W        = 2;
   localparam int LINE_W        = NUM_STAGES * PAIR_W;
   localparam int DRAIN_ROWS    = 3;

   localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
   localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

   localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic                  m;
      logic                  c_gt0;
      logic                  c_lt;
      logic                  w_one;
      logic                  emit;
      logic                  last;
      logic [NUM_STAGES-1:0] up_ok;
      logic [NUM_STAGES-1:0] dn_ok;
   } stage_flags_type;

endpackage

// File: src/rmdb_ram.sv
// ----------------------------------------------------------------------------
// rmdb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/redness_mask_dilate_border_top.sv
// ----------------------------------------------------------------------------
// redness_mask_dilate_border_top
// Red pixel mask, two cross dilations and the boundary of the dilated mask.
// ----------------------------------------------------------------------------
// Pixels enter on req_ in raster order, one word per pixel; req_tuser marks a
// pad word. Each frame is followed by 3*width pad words that drain it. The
// result word for pixel p leaves on rsp_ as a consequence of input word
// p + 3*width; rsp_tlast marks the last pixel of the frame. Pad words inside
// the frame are taken and dropped.
// One word is taken per clock while req_tready is high. A taken word moves
// through the stage register and then the rsp_ result register.
// All three neighborhood stages read and write one shared line RAM (one read
// and one write port), one column per word, which sets the one-word-per-clock
// rate. Frame size is latched on the first word of each frame; csr_ writes
// take effect at the next frame.
// Reset clears the position counters and the pipeline and loads 640 x 480;
// line RAM content is not cleared and is never read for in-frame results.
// When the receiver stalls, the result register holds and one more result
// word waits in the stage register; after that req_tready drops. Words of the
// first three rows of a frame make no result and keep flowing.
// ----------------------------------------------------------------------------
module redness_mask_dilate_border_top
   import rmdb_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // blue, green, red
   input  logic                  req_tuser,   // pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // border_bit, dilated_bit, zeros
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [REG_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

`include "assert_macros.svh"

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);

   logic [CFG_W-1:0]  cfg_width_ff, cfg_width_in;
   logic [CFG_W-1:0]  cfg_height_ff, cfg_height_in;
   logic [WID_W-1:0]  act_w_ff, act_w_in;
   logic [CFG_W-1:0]  act_h_ff, act_h_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              s1_valid_ff, s1_valid_in;
   stage_flags_type   s1_flags_ff, s1_flags_in;
   logic [COL_W-1:0]  s1_col_ff, s1_col_in;
   logic [COL_W-1:0]  raddr_ff, raddr_in;
   logic              byp_ff, byp_in;
   logic [LINE_W-1:0] byp_data_ff, byp_data_in;
   logic [LINE_W-1:0] center_ff, center_in;
   logic [NUM_STAGES-1:0] left_ff, left_in;
   logic [LINE_W-1:0] last_wr_ff, last_wr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_border_ff, rsp_border_in;
   logic              rsp_dilated_ff, rsp_dilated_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [PIX_W-1:0]  blue, green, red;
   logic [PIX_W:0]    gb_sum;
   logic              is_red;
   logic              pos0;
   logic [WID_W-1:0]  clamp_w, eff_w;
   logic [CFG_W-1:0]  clamp_h, eff_h;
   logic [ROW_W-1:0]  h_ext;
   logic              row_in_frame;
   logic              accept, take;
   logic [WID_W-1:0]  col_plus;
   logic              col_wrap;
   logic [COL_W-1:0]  col_next;
   logic [ROW_W-1:0]  row_plus;
   logic [ROW_W-1:0]  row_next;
   logic              s1_adv;
   logic [COL_W-1:0]  raddr_sel;
   logic [LINE_W-1:0] ram_q, right_pair, cen_pair, wr_data;
   logic [NUM_STAGES-1:0] stage_out;

   // input decode and frame size
   always_comb begin
      blue    = req_tdata[PIX_W-1:0];
      green   = req_tdata[2*PIX_W-1:PIX_W];
      red     = req_tdata[3*PIX_W-1:2*PIX_W];
      gb_sum  = {1'b0, green} + {1'b0, blue};
      is_red  = (red != '0) && ({1'b0, red} >= gb_sum);

      if (cfg_width_ff == '0) begin
         clamp_w = WID_W'(1);
      end else if (32'(cfg_width_ff) > 32'(MAX_WIDTH)) begin
         clamp_w = WID_W'(MAX_WIDTH);
      end else begin
         clamp_w = WID_W'(cfg_width_ff);
      end
      clamp_h = (cfg_height_ff == '0) ? CFG_W'(1) : cfg_height_ff;

      pos0  = (row_ff == '0) && (col_ff == '0);
      eff_w = pos0 ? clamp_w : act_w_ff;
      eff_h = pos0 ? clamp_h : act_h_ff;
      h_ext = ROW_W'(eff_h);

      row_in_frame = row_ff < h_ext;
      accept       = req_tvalid && req_tready;
      take         = accept && !(req_tuser && row_in_frame);

      col_plus = WID_W'(col_ff) + WID_W'(1);
      col_wrap = col_plus == eff_w;
      col_next = col_wrap ? '0 : col_plus[COL_W-1:0];
      row_plus = row_ff + ROW_W'(1);
      row_next = (row_plus == h_ext + ROW_W'(DRAIN_ROWS)) ? '0 : row_plus;
   end

   // position counters, size latch, configuration
   always_comb begin
      cfg_width_in  = cfg_width_ff;
      cfg_height_in = cfg_height_ff;
      if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               cfg_width_in = csr_wdata;
            end
            REG_FRAME_HEIGHT: begin
               cfg_height_in = csr_wdata;
            end
            default: begin
               cfg_width_in = cfg_width_ff;
            end
         endcase
      end

      act_w_in = act_w_ff;
      act_h_in = act_h_ff;
      if (accept && pos0) begin
         act_w_in = clamp_w;
         act_h_in = clamp_h;
      end

      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         col_in = col_next;
         if (col_wrap) begin
            row_in = row_next;
         end
      end
   end

   // stage register flags
   always_comb begin
      s1_flags_in.m     = row_in_frame && is_red;
      s1_flags_in.c_gt0 = col_ff != '0;
      s1_flags_in.c_lt  = !col_wrap;
      s1_flags_in.w_one = eff_w == WID_W'(1);
      s1_flags_in.emit  = row_ff >= ROW_W'(DRAIN_ROWS);
      s1_flags_in.last  = (row_ff == h_ext + ROW_W'(DRAIN_ROWS - 1)) && col_wrap;
      for (int j = 0; j < NUM_STAGES; j++) begin
         s1_flags_in.up_ok[j] = row_ff >= ROW_W'(j + 2);
         s1_flags_in.dn_ok[j] = row_ff < h_ext + ROW_W'(j);
      end
      s1_col_in = take ? col_ff : s1_col_ff;
   end

   assign s1_adv     = s1_valid_ff && (!s1_flags_ff.emit || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign raddr_sel  = take ? col_next : raddr_ff;
   assign right_pair = byp_ff ? byp_data_ff : ram_q;
   assign cen_pair   = s1_flags_ff.w_one ? last_wr_ff : center_ff;

   rmdb_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_addr (raddr_sel),
      .rd_data (ram_q)
   );

   // mask -> dilate -> dilate -> border, one row of lag per stage
   always_comb begin
      logic xc, mid, up, lf, rt, y;
      xc = s1_flags_ff.m;
      for (int j = 0; j < NUM_STAGES; j++) begin
         mid = cen_pair[PAIR_W*j];
         up  = cen_pair[PAIR_W*j + 1];
         lf  = left_ff[j];
         rt  = right_pair[PAIR_W*j];
         if (j == NUM_STAGES - 1) begin
            y = mid && ((s1_flags_ff.dn_ok[j] && !xc) || (s1_flags_ff.up_ok[j] && !up)
                        || (s1_flags_ff.c_gt0 && !lf) || (s1_flags_ff.c_lt && !rt));
         end else begin
            y = mid || (s1_flags_ff.dn_ok[j] && xc) || (s1_flags_ff.up_ok[j] && up)
                || (s1_flags_ff.c_gt0 && lf) || (s1_flags_ff.c_lt && rt);
         end
         wr_data[PAIR_W*j +: PAIR_W] = {mid, xc};
         stage_out[j] = y;
         xc = y;
      end
   end

   // stage, window and result register next values
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      raddr_in    = raddr_sel;
      byp_in      = s1_adv && (s1_col_ff == raddr_sel);
      byp_data_in = wr_data;

      center_in  = center_ff;
      left_in    = left_ff;
      last_wr_in = last_wr_ff;
      if (s1_adv) begin
         center_in  = right_pair;
         last_wr_in = wr_data;
         for (int j = 0; j < NUM_STAGES; j++) begin
            left_in[j] = cen_pair[PAIR_W*j];
         end
      end

      rsp_valid_in   = rsp_valid_ff;
      rsp_border_in  = rsp_border_ff;
      rsp_dilated_in = rsp_dilated_ff;
      rsp_last_in    = rsp_last_ff;
      if (s1_adv && s1_flags_ff.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_border_in  = stage_out[NUM_STAGES-1];
         rsp_dilated_in = cen_pair[PAIR_W*(NUM_STAGES-1)];
         rsp_last_in    = s1_flags_ff.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= RESET_WIDTH;
         cfg_height_ff <= RESET_HEIGHT;
         act_w_ff      <= WID_W'(RESET_WIDTH);
         act_h_ff      <= RESET_HEIGHT;
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_width_ff  <= cfg_width_in;
         cfg_height_ff <= cfg_height_in;
         act_w_ff      <= act_w_in;
         act_h_ff      <= act_h_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_flags_ff <= s1_flags_in;
      end
      s1_col_ff      <= s1_col_in;
      raddr_ff       <= raddr_in;
      byp_ff         <= byp_in;
      byp_data_ff    <= byp_data_in;
      center_ff      <= center_in;
      left_ff        <= left_in;
      last_wr_ff     <= last_wr_in;
      rsp_border_ff  <= rsp_border_in;
      rsp_dilated_ff <= rsp_dilated_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 2)'(0), rsp_dilated_ff, rsp_border_ff};
   assign rsp_tlast  = rsp_last_ff;

   `RMDB_ASSERT_IMP(a_stage_drains, clock, reset, s1_valid_ff && !rsp_valid_ff, s1_adv)
   `RMDB_ASSERT_IMP(a_last_wraps, clock, reset, s1_adv && s1_flags_ff.emit && s1_flags_ff.last,
                    row_ff == '0 && col_ff == '0)
   `RMDB_ASSERT_IMP(a_col_in_width, clock, reset, 1'b1, WID_W'(col_ff) < act_w_ff)
   `RMDB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

endmodule

// File: sim/border_mask_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// border_mask_checker
// Watches the pixel, result and register ports of the redness mask block,
// keeps its own copy of the frame size, position and red mask rows, predicts
// the dilated mask and border bit of every pixel and compares each result
// word against the oldest prediction.
// ----------------------------------------------------------------------------
module border_mask_checker
   import rmdb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // blue, green, red
   input  logic                  req_tuser,   // pad
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // border_bit, dilated_bit, zeros
   input  logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [REG_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   output int unsigned           fail_count,
   output int unsigned           pending_results
);

   localparam int RING_ROWS = 8;

   typedef struct packed {
      logic border;
      logic dilated;
      logic last;
   } border_word_type;

   logic [CFG_W-1:0]       width_reg;
   logic [CFG_W-1:0]       height_reg;
   int                     col;
   int                     row;
   int                     act_w;
   int                     act_h;
   int unsigned            errors;
   bit [DEF_MAX_WIDTH-1:0] red_rows [RING_ROWS];
   border_word_type        expected_borders [$];
   border_word_type        want;

   function automatic bit in_frame(input int r, input int c);
      return r >= 0 && c >= 0 && r < act_h && c < act_w;
   endfunction

   function automatic bit red_at(input int r, input int c);
      if (!in_frame(r, c)) return 1'b0;
      return red_rows[r % RING_ROWS][c];
   endfunction

   // any red pixel within city-block distance two
   function automatic bit grown_at(input int r, input int c);
      int span;
      if (!in_frame(r, c)) return 1'b0;
      for (int dr = -2; dr <= 2; dr++) begin
         span = 2 - ((dr < 0) ? -dr : dr);
         for (int dc = -span; dc <= span; dc++) begin
            if (red_at(r + dr, c + dc)) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit border_at(input int r, input int c);
      if (!grown_at(r, c)) return 1'b0;
      return (in_frame(r - 1, c) && !grown_at(r - 1, c)) ||
             (in_frame(r, c - 1) && !grown_at(r, c - 1)) ||
             (in_frame(r + 1, c) && !grown_at(r + 1, c)) ||
             (in_frame(r, c + 1) && !grown_at(r, c + 1));
   endfunction

   task automatic predict_border(input logic [REQ_DATA_W-1:0] pixel, input logic pad);
      int              blue;
      int              green;
      int              red;
      border_word_type res;
      blue  = int'(pixel[PIX_W-1:0]);
      green = int'(pixel[2*PIX_W-1:PIX_W]);
      red   = int'(pixel[3*PIX_W-1:2*PIX_W]);
      if (row == 0 && col == 0) begin
         act_w = (width_reg == 0) ? 1 :
                 ((width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg));
         act_h = (height_reg == 0) ? 1 : int'(height_reg);
      end
      if (row < act_h) begin
         // drop pad words inside the frame
         if (pad) return;
         red_rows[row % RING_ROWS][col] = (red > 0) && (red >= green + blue);
      end
      if (row >= DRAIN_ROWS) begin
         res.dilated = grown_at(row - DRAIN_ROWS, col);
         res.border  = border_at(row - DRAIN_ROWS, col);
         res.last    = (row - DRAIN_ROWS == act_h - 1) && (col == act_w - 1);
         expected_borders.insert(expected_borders.size(), res);
      end
      col++;
      if (col >= act_w) begin
         col = 0;
         row++;
         if (row >= act_h + DRAIN_ROWS) row = 0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         act_w      = int'(RESET_WIDTH);
         act_h      = int'(RESET_HEIGHT);
         col        = 0;
         row        = 0;
         errors     = 0;
         foreach (red_rows[i]) red_rows[i] = '0;
         expected_borders.delete();
         fail_count      <= 0;
         pending_results <= 0;
      end else begin
         if (req_tvalid && req_tready) predict_border(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_borders.size() == 0) begin
               errors++;
               $display("%0t: unexpected result word, expected none, got tdata=%b tlast=%b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = expected_borders.pop_front();
               if (rsp_tdata[0] !== want.border || rsp_tdata[1] !== want.dilated ||
                   rsp_tlast !== want.last || rsp_tdata[RSP_DATA_W-1:2] !== '0) begin
                  errors++;
                  $display("%0t: result mismatch, expected border=%b dilated=%b last=%b",
                           $time, want.border, want.dilated, want.last);
                  $display("%0t:                  got border=%b dilated=%b last=%b fill=%b",
                           $time, rsp_tdata[0], rsp_tdata[1], rsp_tlast,
                           rsp_tdata[RSP_DATA_W-1:2]);
               end
            end
         end
         if (csr_we) begin
            if (csr_index == REG_FRAME_WIDTH) width_reg = csr_wdata;
            else height_reg = csr_wdata;
         end
         fail_count      <= errors;
         pending_results <= expected_borders.size();
      end
   end

endmodule

// File: sim/tb_redness_mask_dilate_border_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_redness_mask_dilate_border_top
// Drives frames of pixels with their drain words into the redness mask block:
// a corner-value frame, clamped and extreme frame sizes, a long receiver
// hold-off, then random frames under several sender and receiver idle mixes.
// A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_redness_mask_dilate_border_top;
   import rmdb_pkg::*;

   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_WORDS   = 320;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // blue, green, red
   logic                  req_tuser  = 1'b0; // pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // border_bit, dilated_bit, zeros
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [REG_IDX_W-1:0]  csr_index  = '0;
   logic [CFG_W-1:0]      csr_wdata  = '0;

   int unsigned fail_count;
   int unsigned pending_results;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_req       = 0;
   int          hold_seen      = 0;
   int          hold_left      = 0;
   int          phase_words    = 0;
   int          send_mix [4]   = '{0, 68, 0, 15};
   int          stall_mix [4]  = '{0, 0, 68, 15};

   // {red, green, blue}: black, ties, one over a tie, minimum red, all ones
   logic [REQ_DATA_W-1:0] corner_pixels [16] = '{
      24'h000000, 24'hFF0000, 24'hFFFFFF, 24'h010000,
      24'hFF9B64, 24'hFF9B65, 24'hFF00FF, 24'hFEFF00,
      24'h140A0A, 24'h000000, 24'h00FFFF, 24'h000001,
      24'h010100, 24'h800000, 24'h7F4040, 24'h808000
   };

   always #5 clock = ~clock;

   redness_mask_dilate_border_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   border_mask_checker u_border_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_req != hold_seen) begin
         rsp_tready <= 1'b0;
         hold_seen  <= hold_req;
         hold_left  <= LONG_HOLD;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   function automatic logic [REQ_DATA_W-1:0] make_pixel(input int red_pct);
      int r;
      int g;
      int b;
      if ($urandom_range(0, 99) < red_pct) begin
         r = $urandom_range(1, 255);
         g = $urandom_range(0, r);
         b = $urandom_range(0, r - g);
      end else begin
         r = $urandom_range(0, 255);
         g = $urandom_range(0, 255);
         b = $urandom_range(0, 255);
      end
      return {r[7:0], g[7:0], b[7:0]};
   endfunction

   task automatic send_word(input logic [REQ_DATA_W-1:0] data, input logic pad);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= pad;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame_size(input int w, input int h);
      csr_we    <= 1'b1;
      csr_index <= REG_FRAME_WIDTH;
      csr_wdata <= CFG_W'(w);
      @(posedge clock);
      csr_index <= REG_FRAME_HEIGHT;
      csr_wdata <= CFG_W'(h);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_frame(input int w, input int h, input int red_pct, input int pad_pct);
      int cols;
      int rows;
      cols = (w < 1) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
      rows = (h < 1) ? 1 : h;
      for (int i = 0; i < cols * rows; i++) begin
         while ($urandom_range(0, 99) < pad_pct) begin
            send_word(REQ_DATA_W'($urandom()), 1'b1);
         end
         send_word(make_pixel(red_pct), 1'b0);
      end
      // drain with mostly pad words, some pixels
      for (int i = 0; i < DRAIN_ROWS * cols; i++) begin
         send_word(REQ_DATA_W'($urandom()), $urandom_range(0, 3) != 0);
      end
      phase_words += (rows + DRAIN_ROWS) * cols;
      req_tvalid <= 1'b0;
      wait_idle();
   endtask

   initial begin
      int w;
      int h;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      set_frame_size(4, 4);

      for (int i = 0; i < 16; i++) begin
         send_word(corner_pixels[i], 1'b0);
         if (i == 0) begin
            // write the next frame's size while this frame is under way
            req_tvalid <= 1'b0;
            wait_idle();
            set_frame_size(0, 5);
         end
         if (i == 5) send_word(24'hFFFFFF, 1'b1);
      end
      for (int i = 0; i < DRAIN_ROWS * 4; i++) begin
         send_word(REQ_DATA_W'($urandom()), i % 2 == 0);
      end
      req_tvalid <= 1'b0;
      wait_idle();

      run_frame(0, 5, 30, 0);
      set_frame_size(20, 0);
      run_frame(20, 0, 10, 1);
      set_frame_size(0, 60);
      run_frame(0, 60, 5, 1);

      set_frame_size(12, 12);
      hold_req <= hold_req + 1;
      run_frame(12, 12, 15, 2);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_mix[p];
         recv_stall_pct = stall_mix[p];
         phase_words    = 0;
         while (phase_words < PHASE_WORDS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 32) : $urandom_range(4, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 16) : $urandom_range(4, 10);
            set_frame_size(w, h);
            run_frame(w, h, $urandom_range(2, 40), $urandom_range(0, 6));
         end
      end

      if (fail_count == 0 && pending_results == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule
